FILE: sv/swps_pkg.sv
// ============================================================================
// swps_pkg
// Shared command and status types for the sliding window peak spread core.
// ============================================================================
package swps_pkg;

    // Width of the window length register.
    localparam int WinCfgBits = 11;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // Capture the accepted input beat.
        logic cfg_wr;    // Write the window length and clear the sequence.
        logic rd_back;   // Read the back of both queues instead of the front.
        logic evict_ck;  // Drop stale entries from the queue fronts.
        logic pop_ck;    // Drop dominated entries from the queue backs.
        logic push;      // Append the current sample to both queues.
        logic front_ck;  // Update the best spread and advance the ring slot.
        logic emit;      // Load the result register and clear the sequence.
    } swps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic evict_hit; // At least one queue dropped a front entry.
        logic pop_hit;   // At least one queue dropped a back entry.
        logic last;      // The held beat closes the sequence.
        logic out_busy;  // The result register cannot take a new result.
    } swps_status_t;

endpackage

FILE: sv/swps_ctrl.sv
// ============================================================================
// swps_ctrl
// Sequencer that steps one sample through queue maintenance and spread update.
// ============================================================================
module swps_ctrl
    import swps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  swps_status_t status,
    output swps_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVICT_RD,
        ST_EVICT_CK,
        ST_POP_RD,
        ST_POP_CK,
        ST_PUSH,
        ST_FRONT_RD,
        ST_FRONT_CK,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.cfg_wr = cfg_valid;
                cmd.load   = s_tvalid && !cfg_valid;
                if (s_tvalid && !cfg_valid)
                begin
                    state_next = ST_EVICT_RD;
                end
            end
            ST_EVICT_RD:
            begin
                state_next = ST_EVICT_CK;
            end
            ST_EVICT_CK:
            begin
                cmd.evict_ck = 1'b1;
                state_next   = status.evict_hit ? ST_EVICT_RD : ST_POP_RD;
            end
            ST_POP_RD:
            begin
                cmd.rd_back = 1'b1;
                state_next  = ST_POP_CK;
            end
            ST_POP_CK:
            begin
                cmd.pop_ck = 1'b1;
                state_next = status.pop_hit ? ST_POP_RD : ST_PUSH;
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_FRONT_RD;
            end
            ST_FRONT_RD:
            begin
                state_next = ST_FRONT_CK;
            end
            ST_FRONT_CK:
            begin
                cmd.front_ck = 1'b1;
                state_next   = status.last ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/swps_dp.sv
// ============================================================================
// swps_dp
// Datapath with the two monotonic candidate queues, spread tracking and output.
// ============================================================================
module swps_dp
    import swps_pkg::*;
#(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 28
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  swps_cmd_t              cmd,
    output swps_status_t           status,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   in_last,
    input  logic [WinCfgBits-1:0]  cfg_window,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_spread
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int EW = CW + 1;
    localparam int QW = AW + SAMPLE_BITS;

    // Queue entries hold the ring slot and the sample value side by side.
    logic [QW-1:0] qmax_mem [MAX_WINDOW];
    logic [QW-1:0] qmin_mem [MAX_WINDOW];
    logic [QW-1:0] qmax_rd;
    logic [QW-1:0] qmin_rd;

    logic [WinCfgBits-1:0]  win_reg;
    logic [SAMPLE_BITS-1:0] v_reg;
    logic                   last_reg;
    logic [AW-1:0]          slot_reg;
    logic [CW-1:0]          seen_reg;
    logic [SAMPLE_BITS-1:0] best_reg;
    logic [AW-1:0]          hmax_reg;
    logic [AW-1:0]          hmin_reg;
    logic [CW-1:0]          cmax_reg;
    logic [CW-1:0]          cmin_reg;
    logic                   ovalid_reg;
    logic [SAMPLE_BITS-1:0] ospread_reg;

    logic [31:0]            win32;
    logic [31:0]            w32;
    logic [CW-1:0]          w;
    logic [AW-1:0]          amax;
    logic [AW-1:0]          amin;
    logic                   ev_max;
    logic                   ev_min;
    logic                   pop_max;
    logic                   pop_min;
    logic [SAMPLE_BITS-1:0] span;
    logic                   clear;

    // Ring index a + b, with a below MAX_WINDOW and b at most MAX_WINDOW.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [EW:0] s;
        s = (EW+1)'(a) + (EW+1)'(b);
        if (s >= (EW+1)'(MAX_WINDOW))
        begin
            s = s - (EW+1)'(MAX_WINDOW);
        end
        return s[AW-1:0];
    endfunction

    // Age of a slot relative to the current write slot, modulo the ring size.
    function automatic logic [EW-1:0] slot_age(input logic [AW-1:0] cur, input logic [AW-1:0] s);
        logic [EW-1:0] age;
        if (cur >= s)
        begin
            age = EW'(cur) - EW'(s);
        end
        else
        begin
            age = EW'(cur) + EW'(MAX_WINDOW) - EW'(s);
        end
        return age;
    endfunction

    assign win32 = 32'(win_reg);
    assign w32   = (win32 == 32'd0) ? 32'd1 :
                   ((win32 > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : win32);
    assign w     = w32[CW-1:0];

    assign amax = cmd.rd_back ? ring_add(hmax_reg, cmax_reg - CW'(1)) : hmax_reg;
    assign amin = cmd.rd_back ? ring_add(hmin_reg, cmin_reg - CW'(1)) : hmin_reg;

    // A front entry is stale once it is a full window old or its slot is reused.
    always_comb
    begin
        ev_max = (cmax_reg != '0) &&
                 ((slot_age(slot_reg, qmax_rd[QW-1:SAMPLE_BITS]) >= EW'(w)) ||
                  (slot_age(slot_reg, qmax_rd[QW-1:SAMPLE_BITS]) == '0));
        ev_min = (cmin_reg != '0) &&
                 ((slot_age(slot_reg, qmin_rd[QW-1:SAMPLE_BITS]) >= EW'(w)) ||
                  (slot_age(slot_reg, qmin_rd[QW-1:SAMPLE_BITS]) == '0));
    end

    assign pop_max = (cmax_reg != '0) && (qmax_rd[SAMPLE_BITS-1:0] <= v_reg);
    assign pop_min = (cmin_reg != '0) && (qmin_rd[SAMPLE_BITS-1:0] >= v_reg);
    assign span    = qmax_rd[SAMPLE_BITS-1:0] - qmin_rd[SAMPLE_BITS-1:0];
    assign clear   = cmd.cfg_wr || cmd.emit;

    assign status.evict_hit = ev_max || ev_min;
    assign status.pop_hit   = pop_max || pop_min;
    assign status.last      = last_reg;
    assign status.out_busy  = ovalid_reg && !out_ready;

    assign out_valid  = ovalid_reg;
    assign out_spread = ospread_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            qmax_mem[ring_add(hmax_reg, cmax_reg)] <= {slot_reg, v_reg};
            qmin_mem[ring_add(hmin_reg, cmin_reg)] <= {slot_reg, v_reg};
        end
        qmax_rd <= qmax_mem[amax];
        qmin_rd <= qmin_mem[amin];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg    <= in_sample;
            last_reg <= in_last;
        end
        if (cmd.emit)
        begin
            ospread_reg <= (seen_reg >= w) ? best_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= WinCfgBits'(1);
            slot_reg   <= '0;
            seen_reg   <= '0;
            best_reg   <= '0;
            hmax_reg   <= '0;
            hmin_reg   <= '0;
            cmax_reg   <= '0;
            cmin_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_wr)
            begin
                win_reg <= cfg_window;
            end
            if (cmd.emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (clear)
            begin
                slot_reg <= '0;
                seen_reg <= '0;
                best_reg <= '0;
                hmax_reg <= '0;
                hmin_reg <= '0;
                cmax_reg <= '0;
                cmin_reg <= '0;
            end
            else
            begin
                if (cmd.evict_ck)
                begin
                    if (ev_max)
                    begin
                        hmax_reg <= ring_add(hmax_reg, CW'(1));
                        cmax_reg <= cmax_reg - CW'(1);
                    end
                    if (ev_min)
                    begin
                        hmin_reg <= ring_add(hmin_reg, CW'(1));
                        cmin_reg <= cmin_reg - CW'(1);
                    end
                end
                if (cmd.pop_ck)
                begin
                    if (pop_max)
                    begin
                        cmax_reg <= cmax_reg - CW'(1);
                    end
                    if (pop_min)
                    begin
                        cmin_reg <= cmin_reg - CW'(1);
                    end
                end
                if (cmd.push)
                begin
                    cmax_reg <= cmax_reg + CW'(1);
                    cmin_reg <= cmin_reg + CW'(1);
                    if (seen_reg < w)
                    begin
                        seen_reg <= seen_reg + CW'(1);
                    end
                end
                if (cmd.front_ck)
                begin
                    if ((seen_reg >= w) && (span > best_reg))
                    begin
                        best_reg <= span;
                    end
                    slot_reg <= ring_add(slot_reg, CW'(1));
                end
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmax_reg <= CW'(MAX_WINDOW)) && (cmin_reg <= CW'(MAX_WINDOW)))
        else $error("candidate queue count exceeds its depth");
    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> (cmax_reg != '0) && (cmin_reg != '0))
        else $error("queue empty right after a push");
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= w)
        else $error("sample count passed the window length");
    a_emit_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> ovalid_reg)
        else $error("result not presented after emit");
`endif

endmodule

FILE: sv/sliding_window_peak_spread_core.sv
// Sequence: after a beat is taken the core checks the queue fronts, each check after a registered
// read, while a stale front is dropped, then the queue backs while a dominated back is dropped (both
// queues in one pass), then pushes, reads the fronts and updates the spread. A new sample is taken
// only in idle; a last sample then loads the result when the output is free, shown the cycle after.
// Reset: rst_n is asynchronous and active low; it empties both queues, clears the count and best
// spread, and sets the window length to 1. Queue memories are not cleared.
// ============================================================================
// sliding_window_peak_spread_core
// Streams unsigned samples and reports the largest sliding window spread
// (window maximum minus window minimum) on the beat marked last.
// ============================================================================
module sliding_window_peak_spread_core
    import swps_pkg::*;
#(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 28
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input beats: tdata holds sample from bit 0 up, zero filled to bytes.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    input  logic                                s_tlast,
    // Result beats: tdata holds spread from bit 0 up, zero filled to bytes.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
    // Window length register write.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [WinCfgBits-1:0]               cfg_data
);

    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;

    swps_cmd_t              cmd;
    swps_status_t           status;
    logic [SAMPLE_BITS-1:0] spread;

    // The controller walks each sample through front eviction, back popping,
    // the push and the spread update; the datapath owns all the storage.
    swps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    swps_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .in_last    (s_tlast),
        .cfg_window (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_spread (spread)
    );

    // Bits above the sample width are zero fill.
    assign m_tdata = DW'(spread);

endmodule
